// ----- design/sqc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqc_pkg
// Shared constants and types of the smallest-three quaternion codec.
// ----------------------------------------------------------------------------
package sqc_pkg;

  // Default configuration of the codec.
  localparam int FIELD_BITS_DEF    = 9;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int SQRT_STEP_DEF     = 2;

  // Fixed field widths of the stream payload.
  localparam int COMP_W      = 16;
  localparam int CODE_W      = 32;
  localparam int IN_TDATA_W  = 4 * COMP_W + CODE_W;
  localparam int OUT_TDATA_W = CODE_W + 4 * COMP_W;

  // Direction codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Component index of w; the default winner of the largest-magnitude search.
  localparam logic [1:0] IDX_W = 2'd3;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic       dir;
    logic [1:0] idx;
  } sqc_ctrl_t;

endpackage
`default_nettype wire

// ----- design/sqc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqc_front
// Three pipeline stages: component selection or dequantization, then
// quantization or squaring, then the square-root radicand.
// ----------------------------------------------------------------------------
module sqc_front
  import sqc_pkg::*;
#(
  parameter int FIELD_BITS    = FIELD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int VW = FRACTION_BITS + 2,
  localparam int RW = 2 * FRACTION_BITS + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     direction,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [COMP_W-1:0] comp_x,
  input  wire logic signed [COMP_W-1:0] comp_y,
  input  wire logic signed [COMP_W-1:0] comp_z,
  input  wire logic signed [COMP_W-1:0] comp_w,
  input  wire logic [CODE_W-1:0]        packed_code,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output sqc_ctrl_t                     out_ctrl,
  output logic [CODE_W-1:0]             out_word,
  output logic signed [VW-1:0]          out_v0,
  output logic signed [VW-1:0]          out_v1,
  output logic signed [VW-1:0]          out_v2,
  output logic [RW-1:0]                 out_rad
);

  localparam int AW = COMP_W + 1;
  localparam int TW = (FRACTION_BITS + 2 > AW + 1) ? FRACTION_BITS + 2 : AW + 1;
  localparam int CW = TW + FIELD_BITS;
  localparam int NW = FIELD_BITS + FRACTION_BITS + 2;
  localparam int SW = RW + 2;

  localparam logic [FIELD_BITS-1:0] CODE_TOP = '1;
  localparam logic signed [TW-1:0]  EN_ONE   = TW'(1) << FRACTION_BITS;
  localparam logic [NW-1:0]         DQ_HALF  = NW'(1) << (FIELD_BITS - 1);
  localparam logic [NW-1:0]         DQ_ONE   = NW'(1) << FRACTION_BITS;
  localparam logic [SW-1:0]         FULL     = SW'(1) << (2 * FRACTION_BITS);

  logic rdy1, rdy2, rdy3;

  // Stage 1 logic
  logic signed [AW-1:0]    q_ext [4];
  logic [AW-1:0]           q_abs [4];
  logic [AW-1:0]           max_abs;
  logic [1:0]              sel_idx;
  logic                    sel_neg;
  logic [FIELD_BITS-1:0]   dq_code [3];
  logic [NW-1:0]           dq_num [3];
  logic [NW-1:0]           dq_diff [3];
  logic signed [VW-1:0]    dq_v [3];

  // Stage 1 registers
  logic                    s1_valid;
  sqc_ctrl_t               s1_ctrl;
  logic signed [COMP_W-1:0] s1_q [4];
  logic                    s1_neg;
  logic signed [VW-1:0]    s1_v [3];

  // Stage 2 logic
  logic [1:0]              en_pos [3];
  logic signed [AW-1:0]    en_val [3];
  logic signed [TW-1:0]    en_t [3];
  logic [CW-1:0]           en_c [3];
  logic [FIELD_BITS-1:0]   en_field [3];
  logic [CODE_W-1:0]       en_word;
  logic signed [2*VW-1:0]  sq_full [3];

  // Stage 2 registers
  logic                    s2_valid;
  sqc_ctrl_t               s2_ctrl;
  logic [CODE_W-1:0]       s2_word;
  logic signed [VW-1:0]    s2_v [3];
  logic [RW-1:0]           s2_sq [3];

  // Stage 3 logic
  logic [SW-1:0]           sq_sum;
  logic [SW-1:0]           rad_diff;
  logic [RW-1:0]           rad;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // Largest magnitude wins; w is checked first and only a strictly larger
  // magnitude takes over.
  always_comb begin
    q_ext[0] = AW'(comp_x);
    q_ext[1] = AW'(comp_y);
    q_ext[2] = AW'(comp_z);
    q_ext[3] = AW'(comp_w);
    for (int k = 0; k < 4; k++) begin
      q_abs[k] = q_ext[k][AW-1] ? AW'(-q_ext[k]) : AW'(q_ext[k]);
    end
    sel_idx = IDX_W;
    max_abs = q_abs[3];
    for (int k = 0; k < 3; k++) begin
      if (q_abs[k] > max_abs) begin
        sel_idx = 2'(k);
        max_abs = q_abs[k];
      end
    end
    sel_neg = q_ext[sel_idx][AW-1];
  end

  // Cell midpoint of each field, rounded half up.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dq_code[k] = packed_code[k*FIELD_BITS +: FIELD_BITS];
      dq_num[k]  = (NW'({dq_code[k], 1'b1}) << FRACTION_BITS) + DQ_HALF;
      dq_diff[k] = (dq_num[k] >> FIELD_BITS) - DQ_ONE;
      dq_v[k]    = dq_diff[k][VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_ctrl.dir <= direction;
      s1_ctrl.idx <= (direction == DIR_DECODE) ? packed_code[CODE_W-1 -: 2] : sel_idx;
      s1_q[0]     <= comp_x;
      s1_q[1]     <= comp_y;
      s1_q[2]     <= comp_z;
      s1_q[3]     <= comp_w;
      s1_neg      <= sel_neg;
      for (int k = 0; k < 3; k++) begin
        s1_v[k] <= dq_v[k];
      end
    end
  end

  // Quantize the three following components after flipping them by the sign
  // of the dropped one; squares of the decoded values in parallel.
  always_comb begin
    en_word = '0;
    en_word[CODE_W-1 -: 2] = s1_ctrl.idx;
    for (int k = 0; k < 3; k++) begin
      en_pos[k] = s1_ctrl.idx + 2'(k + 1);
      en_val[k] = s1_neg ? -AW'(s1_q[en_pos[k]]) : AW'(s1_q[en_pos[k]]);
      en_t[k]   = TW'(en_val[k]) + EN_ONE;
      en_c[k]   = (CW'($unsigned(en_t[k])) << FIELD_BITS) >> (FRACTION_BITS + 1);
      if (en_t[k][TW-1]) begin
        en_field[k] = '0;
      end else if (en_c[k] > CW'(CODE_TOP)) begin
        en_field[k] = CODE_TOP;
      end else begin
        en_field[k] = en_c[k][FIELD_BITS-1:0];
      end
      en_word[k*FIELD_BITS +: FIELD_BITS] = en_field[k];
      sq_full[k] = s1_v[k] * s1_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      s2_ctrl <= s1_ctrl;
      s2_word <= en_word;
      for (int k = 0; k < 3; k++) begin
        s2_v[k]  <= s1_v[k];
        s2_sq[k] <= sq_full[k][RW-1:0];
      end
    end
  end

  // A norm of one or more leaves nothing for the dropped component.
  always_comb begin
    sq_sum   = SW'(s2_sq[0]) + SW'(s2_sq[1]) + SW'(s2_sq[2]);
    rad_diff = FULL - sq_sum;
    rad      = (sq_sum >= FULL) ? '0 : rad_diff[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid) begin
      out_ctrl <= s2_ctrl;
      out_word <= s2_word;
      out_v0   <= s2_v[0];
      out_v1   <= s2_v[1];
      out_v2   <= s2_v[2];
      out_rad  <= rad;
    end
  end

endmodule
`default_nettype wire

// ----- design/sqc_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqc_sqrt
// Pipelined integer square root, a few result bits per stage, with a
// payload carried alongside.
// ----------------------------------------------------------------------------
module sqc_sqrt
  import sqc_pkg::*;
#(
  parameter int RAD_W     = 2 * FRACTION_BITS_DEF + 1,
  parameter int STEP_BITS = SQRT_STEP_DEF,
  parameter int PAY_W     = CODE_W,
  localparam int RES_W    = (RAD_W + 1) / 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [RAD_W-1:0] in_rad,
  input  wire logic [PAY_W-1:0] in_pay,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [RES_W-1:0]      out_root,
  output logic [PAY_W-1:0]      out_pay
);

  localparam int NS   = (RES_W + STEP_BITS - 1) / STEP_BITS;
  localparam int N    = NS * STEP_BITS;
  localparam int PADW = 2 * N;
  localparam int REMW = N + 2;

  logic              st_valid [NS];
  logic [REMW-1:0]   st_rem [NS];
  logic [N-1:0]      st_root [NS];
  logic [PADW-1:0]   st_rad [NS];
  logic [PAY_W-1:0]  st_pay [NS];

  logic              src_valid [NS];
  logic [PAY_W-1:0]  src_pay [NS];
  logic [REMW-1:0]   nxt_rem [NS];
  logic [N-1:0]      nxt_root [NS];
  logic [PADW-1:0]   nxt_rad [NS];
  logic [REMW-1:0]   trial [NS];
  logic              rdy [NS+1];

  // Restoring square root: each step brings down two radicand bits and
  // tries the next root bit.
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        src_valid[s] = in_valid;
        src_pay[s]   = in_pay;
        nxt_rem[s]   = '0;
        nxt_root[s]  = '0;
        nxt_rad[s]   = PADW'(in_rad);
      end else begin
        src_valid[s] = st_valid[s-1];
        src_pay[s]   = st_pay[s-1];
        nxt_rem[s]   = st_rem[s-1];
        nxt_root[s]  = st_root[s-1];
        nxt_rad[s]   = st_rad[s-1];
      end
      trial[s] = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
        nxt_rem[s] = {nxt_rem[s][REMW-3:0], nxt_rad[s][PADW-1 -: 2]};
        nxt_rad[s] = nxt_rad[s] << 2;
        trial[s]   = {nxt_root[s], 2'b01};
        if (nxt_rem[s] >= trial[s]) begin
          nxt_rem[s]  = nxt_rem[s] - trial[s];
          nxt_root[s] = {nxt_root[s][N-2:0], 1'b1};
        end else begin
          nxt_root[s] = {nxt_root[s][N-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    rdy[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !st_valid[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) begin
        st_valid[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          st_valid[s] <= src_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s] && src_valid[s]) begin
        st_rem[s]  <= nxt_rem[s];
        st_root[s] <= nxt_root[s];
        st_rad[s]  <= nxt_rad[s];
        st_pay[s]  <= src_pay[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = st_valid[NS-1];
  assign out_root  = st_root[NS-1][RES_W-1:0];
  assign out_pay   = st_pay[NS-1];

endmodule
`default_nettype wire

// ----- design/smallest_three_quat_codec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_three_quat_codec
// Smallest-three unit quaternion encoder and decoder on stream channels.
// ----------------------------------------------------------------------------
// The slave channel carries one quaternion or one code word per transfer;
// the direction register (cfg_we / cfg_wdata, 0 encodes, 1 decodes) picks
// which fields are used, and it is sampled with each accepted transfer.
// The master channel returns one result per input transfer, in order: the
// 32-bit code word when encoding, the four Q1.14 components when decoding,
// with the unused fields driven to zero.
// Throughput is one transfer per cycle while m_tready stays high. Results
// pass through the front end, the square-root pipeline of depth
// NS = ceil((FRACTION_BITS + 1) / STEP_BITS), whose stages settle
// STEP_BITS root bits each, and the output register.
// Every stage keeps its own valid bit and is refilled whenever it is empty
// or its successor moves, so bubbles close up while m_tready is low and new
// transfers are still taken until the whole pipeline is full. Nothing is
// lost or repeated across a stall.
// Reset (rst, synchronous) empties the pipeline and selects encoding.
// ----------------------------------------------------------------------------
module smallest_three_quat_codec
  import sqc_pkg::*;
#(
  parameter int FIELD_BITS    = FIELD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int STEP_BITS     = SQRT_STEP_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // comp_x [15:0], comp_y [31:16], comp_z [47:32], comp_w [63:48],
  // packed_code [95:64]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // code_word [31:0], out_x [47:32], out_y [63:48], out_z [79:64],
  // out_w [95:80]
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam int VW    = FRACTION_BITS + 2;
  localparam int RW    = 2 * FRACTION_BITS + 1;
  localparam int RES_W = (RW + 1) / 2;

  // Everything the square-root stages carry along for the final assembly.
  typedef struct packed {
    sqc_ctrl_t            ctrl;
    logic [CODE_W-1:0]    word;
    logic signed [VW-1:0] v2;
    logic signed [VW-1:0] v1;
    logic signed [VW-1:0] v0;
  } pay_t;

  localparam int PAY_W = $bits(pay_t);

  logic                    direction;

  logic                    fr_valid;
  logic                    fr_ready;
  sqc_ctrl_t               fr_ctrl;
  logic [CODE_W-1:0]       fr_word;
  logic signed [VW-1:0]    fr_v0;
  logic signed [VW-1:0]    fr_v1;
  logic signed [VW-1:0]    fr_v2;
  logic [RW-1:0]           fr_rad;
  pay_t                    fr_pay;

  logic                    sq_valid;
  logic                    sq_ready;
  logic [RES_W-1:0]        sq_root;
  logic [PAY_W-1:0]        sq_pay;
  pay_t                    po;

  logic [31:0]             root_ext;
  logic signed [31:0]      v_ext [3];
  logic [COMP_W-1:0]       comp [4];
  logic [1:0]              rel;
  logic [CODE_W-1:0]       code_word;
  logic [COMP_W-1:0]       out_x, out_y, out_z, out_w;

  // Direction register; write it only while idle (the block does not check).
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
    end
  end

  sqc_front #(
    .FIELD_BITS    (FIELD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .direction   (direction),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .comp_x      (s_tdata[COMP_W-1:0]),
    .comp_y      (s_tdata[2*COMP_W-1:COMP_W]),
    .comp_z      (s_tdata[3*COMP_W-1:2*COMP_W]),
    .comp_w      (s_tdata[4*COMP_W-1:3*COMP_W]),
    .packed_code (s_tdata[4*COMP_W+CODE_W-1:4*COMP_W]),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_ctrl    (fr_ctrl),
    .out_word    (fr_word),
    .out_v0      (fr_v0),
    .out_v1      (fr_v1),
    .out_v2      (fr_v2),
    .out_rad     (fr_rad)
  );

  always_comb begin
    fr_pay.ctrl = fr_ctrl;
    fr_pay.word = fr_word;
    fr_pay.v0   = fr_v0;
    fr_pay.v1   = fr_v1;
    fr_pay.v2   = fr_v2;
  end

  sqc_sqrt #(
    .RAD_W     (RW),
    .STEP_BITS (STEP_BITS),
    .PAY_W     (PAY_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_pay    (fr_pay),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  assign po = sq_pay;

  // The rebuilt component lands at the dropped index and the three decoded
  // values follow it in cyclic order. Each output keeps its low 16 bits.
  always_comb begin
    root_ext = 32'(sq_root);
    v_ext[0] = 32'(po.v0);
    v_ext[1] = 32'(po.v1);
    v_ext[2] = 32'(po.v2);
    rel      = '0;
    for (int p = 0; p < 4; p++) begin
      rel = 2'(p) - po.ctrl.idx;
      unique case (rel)
        2'd0:    comp[p] = root_ext[COMP_W-1:0];
        2'd1:    comp[p] = v_ext[0][COMP_W-1:0];
        2'd2:    comp[p] = v_ext[1][COMP_W-1:0];
        default: comp[p] = v_ext[2][COMP_W-1:0];
      endcase
    end
    unique case (po.ctrl.dir)
      DIR_ENCODE: begin
        code_word = po.word;
        out_x     = '0;
        out_y     = '0;
        out_z     = '0;
        out_w     = '0;
      end
      default: begin
        code_word = '0;
        out_x     = comp[0];
        out_y     = comp[1];
        out_z     = comp[2];
        out_w     = comp[3];
      end
    endcase
  end

  // Output register; it takes a new result whenever it is empty or its
  // current one is being transferred.
  assign sq_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sq_ready) begin
      m_tvalid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && sq_valid) begin
      m_tdata <= {out_w, out_z, out_y, out_x, code_word};
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smallest-three quaternion codec.
// ----------------------------------------------------------------------------
// Quaternions and code words are streamed into the codec in both directions.
// Every accepted transfer is run through a behavioral codec model kept in
// this bench, and the expected result is queued. Each result transfer is
// checked field by field against the oldest queued entry. The sender works
// in bursts with random gaps, the receiver stalls on a changing pattern, and
// one long receiver hold-off fills the pipeline so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import sqc_pkg::*;

  // The bench models the codec at its default sizes.
  localparam int FIELD_BITS    = FIELD_BITS_DEF;
  localparam int FRACTION_BITS = FRACTION_BITS_DEF;
  localparam int CODE_TOP      = (1 << FIELD_BITS) - 1;
  localparam int ONE_FIX       = 1 << FRACTION_BITS;
  localparam longint FULL_NORM = longint'(1) << (2 * FRACTION_BITS);

  // Front end, square-root stages and the output register.
  localparam int PIPE_LATENCY =
    3 + (FRACTION_BITS + SQRT_STEP_DEF) / SQRT_STEP_DEF + 1;

  // Roughly a hundred times the slowest legal run of this stimulus.
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MAX_REPORTS = 10;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [CODE_W-1:0]        code_word;
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
  } codec_result_t;

  // Receiver behavior, switched to a random mode for runs of random length.
  typedef enum int {READY_FREE, READY_LIGHT, READY_HEAVY, READY_PERIODIC} ready_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // comp_x [15:0], comp_y [31:16], comp_z [47:32], comp_w [63:48],
  // packed_code [95:64]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // code_word [31:0], out_x [47:32], out_y [63:48], out_z [79:64],
  // out_w [95:80]
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Results the codec still owes, oldest first.
  codec_result_t pending_results[$];

  // Direction the codec holds, as last written.
  logic cur_direction = DIR_ENCODE;

  int error_count = 0;
  int result_count = 0;

  // Sender burst control; gaps can be switched off by a test.
  int burst_left = 0;
  bit gaps_enabled = 1'b1;

  // A nonzero value asks the receiver for a hold-off of that many cycles.
  int hold_request = 0;

  smallest_three_quat_codec u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral codec model
  // --------------------------------------------------------------------------

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Maps [-1.0, 1.0) onto the field codes; values outside clamp to the ends.
  function automatic int quantize_component(input int v);
    int shifted;
    int code_val;
    shifted = v + ONE_FIX;
    if (shifted < 0) begin
      return 0;
    end
    code_val = (shifted << FIELD_BITS) >> (FRACTION_BITS + 1);
    return (code_val > CODE_TOP) ? CODE_TOP : code_val;
  endfunction

  // Center of the cell a field code stands for, rounded half up.
  function automatic int cell_center(input logic [CODE_W-1:0] bits);
    int code;
    int scaled;
    code = int'(bits[FIELD_BITS-1:0]);
    scaled = (2 * code + 1) << FRACTION_BITS;
    return ((scaled + (1 << (FIELD_BITS - 1))) >> FIELD_BITS) - ONE_FIX;
  endfunction

  // Largest root whose square does not exceed the argument.
  function automatic int floor_sqrt(input longint v);
    int root;
    int trial;
    root = 0;
    for (int b = FRACTION_BITS + 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (longint'(trial) * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Expected result of one input transfer in the given direction.
  function automatic codec_result_t predict_codec_result(input logic dir,
                                                         input logic [IN_TDATA_W-1:0] data);
    codec_result_t res;
    int comp[4];
    int part[3];
    int largest;
    int winner;
    int sign_mul;
    int lane;
    logic [CODE_W-1:0] word;
    longint norm_sq;
    res = '0;
    if (dir == DIR_ENCODE) begin
      for (int k = 0; k < 4; k++) begin
        comp[k] = int'($signed(data[k*COMP_W +: COMP_W]));
      end
      // w is the default and only a strictly larger magnitude takes over.
      winner = IDX_W;
      largest = magnitude(comp[IDX_W]);
      for (int k = 0; k < 3; k++) begin
        if (magnitude(comp[k]) > largest) begin
          winner = k;
          largest = magnitude(comp[k]);
        end
      end
      // A zero winner counts as positive.
      sign_mul = (comp[winner] >= 0) ? 1 : -1;
      word = '0;
      word[CODE_W-1 -: 2] = winner[1:0];
      lane = winner;
      for (int k = 0; k < 3; k++) begin
        lane = (lane + 1) % 4;
        word = word | (CODE_W'(quantize_component(sign_mul * comp[lane])) << (FIELD_BITS * k));
      end
      res.code_word = word;
    end else begin
      word = data[4*COMP_W +: CODE_W];
      winner = int'(word[CODE_W-1 -: 2]);
      norm_sq = 0;
      for (int k = 0; k < 3; k++) begin
        part[k] = cell_center(word >> (FIELD_BITS * k));
        norm_sq += longint'(part[k]) * part[k];
      end
      // A norm of one or more leaves nothing for the dropped component.
      comp[winner] = (norm_sq >= FULL_NORM) ? 0 : floor_sqrt(FULL_NORM - norm_sq);
      lane = winner;
      for (int k = 0; k < 3; k++) begin
        lane = (lane + 1) % 4;
        comp[lane] = part[k];
      end
      res.out_x = COMP_W'(comp[0]);
      res.out_y = COMP_W'(comp[1]);
      res.out_z = COMP_W'(comp[2]);
      res.out_w = COMP_W'(comp[3]);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [IN_TDATA_W-1:0] pack_item(input int x, input int y, input int z,
                                                      input int w, input logic [CODE_W-1:0] code);
    return {code, COMP_W'(w), COMP_W'(z), COMP_W'(y), COMP_W'(x)};
  endfunction

  function automatic logic [CODE_W-1:0] make_code(input int idx, input int f0, input int f1,
                                                  input int f2, input int spare);
    logic [CODE_W-1:0] word;
    word = CODE_W'(idx) << (CODE_W - 2);
    word = word | (CODE_W'(spare) << (3 * FIELD_BITS));
    word = word | (CODE_W'(f2 & CODE_TOP) << (2 * FIELD_BITS));
    word = word | (CODE_W'(f1 & CODE_TOP) << FIELD_BITS);
    word = word | CODE_W'(f0 & CODE_TOP);
    return word;
  endfunction

  function automatic int random_component();
    return int'($urandom_range(0, 2 * ONE_FIX)) - ONE_FIX;
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(0, 6))
      0:       return -ONE_FIX;
      1:       return -ONE_FIX + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return ONE_FIX - 1;
      default: return ONE_FIX;
    endcase
  endfunction

  // Plain random quaternions most often, plus near-unit, tied and extreme ones.
  function automatic logic [IN_TDATA_W-1:0] random_quaternion_item();
    int c[4];
    int pick;
    int mag;
    int big;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      for (int k = 0; k < 4; k++) begin
        c[k] = random_component();
      end
    end else if (pick < 62) begin
      // Equal magnitudes exercise the tie rule.
      mag = $urandom_range(0, ONE_FIX);
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          c[k] = int'($urandom_range(0, mag));
        end else begin
          c[k] = mag;
        end
        if ($urandom_range(0, 1) == 1) begin
          c[k] = -c[k];
        end
      end
    end else if (pick < 88) begin
      big = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
        c[k] = int'($urandom_range(0, 12000)) - 6000;
      end
      c[big] = ONE_FIX - int'($urandom_range(0, 3000));
      if ($urandom_range(0, 1) == 1) begin
        c[big] = -c[big];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        c[k] = extreme_value();
      end
    end
    return pack_item(c[0], c[1], c[2], c[3], $urandom);
  endfunction

  // Random code words, with a share whose fields sit near the middle so the
  // rebuilt component comes out close to one.
  function automatic logic [IN_TDATA_W-1:0] random_code_item();
    logic [CODE_W-1:0] word;
    int mid;
    mid = 1 << (FIELD_BITS - 1);
    if ($urandom_range(0, 3) != 0) begin
      word = $urandom;
    end else begin
      word = make_code($urandom_range(0, 3),
                       mid + int'($urandom_range(0, 60)) - 30,
                       mid + int'($urandom_range(0, 60)) - 30,
                       mid + int'($urandom_range(0, 60)) - 30,
                       $urandom);
    end
    return pack_item($urandom, $urandom, $urandom, $urandom, word);
  endfunction

  // Offers one item, waits for its transfer, queues the expected result and
  // then, at the end of a burst, leaves a random gap.
  task automatic send_item(input logic [IN_TDATA_W-1:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_codec_result(cur_direction, data));
    if (gaps_enabled) begin
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          s_tdata  <= {$urandom, $urandom, $urandom};
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Waits until the codec is empty, then writes the direction register.
  task automatic set_direction(input logic dir);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    cur_direction = dir;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Runs in the direction selected by reset, so the reset value is covered.
  task automatic test_encode_directed();
    send_item(pack_item(0, 0, 0, 0, $urandom));                 // zero winner is positive
    send_item(pack_item(0, 0, 0, ONE_FIX, $urandom));
    send_item(pack_item(0, 0, 0, -ONE_FIX, $urandom));
    send_item(pack_item(ONE_FIX, 0, 0, 0, $urandom));
    send_item(pack_item(0, -ONE_FIX, 0, 0, $urandom));
    send_item(pack_item(0, 0, ONE_FIX, 0, $urandom));
    send_item(pack_item(8192, -8192, 8192, -8192, $urandom));   // four-way tie goes to w
    send_item(pack_item(-12000, 12000, 0, 0, $urandom));        // x beats y on a tie
    send_item(pack_item(ONE_FIX - 1, -ONE_FIX, ONE_FIX, 1 - ONE_FIX, $urandom));
    send_item(pack_item(-20000, 5000, -3000, 25000, $urandom)); // below -1.0 clamps low
    send_item(pack_item(32767, -32767, 100, 0, $urandom));      // x wins the tie, y clamps low
    send_item(pack_item(1, -1, 1, -1, $urandom));
    send_item(pack_item(0, 0, 0, -1, $urandom));
  endtask

  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_item(pack_item($urandom, $urandom, $urandom, $urandom, make_code(3, 0, 0, 0, 0)));
    send_item(pack_item($urandom, $urandom, $urandom, $urandom, make_code(1, 0, 0, 0, 7)));
    send_item(pack_item(0, 0, 0, 0, make_code(2, CODE_TOP, CODE_TOP, CODE_TOP, 0)));
    send_item(pack_item(0, 0, 0, 0, make_code(3, CODE_TOP, CODE_TOP, CODE_TOP, 7)));
    send_item(pack_item(0, 0, 0, 0, make_code(0, 255, 256, 255, 5)));
    send_item(pack_item(0, 0, 0, 0, make_code(1, 256, 256, 256, 2)));
    send_item(pack_item(0, 0, 0, 0, make_code(2, 0, CODE_TOP, 256, 0)));
    send_item(pack_item(0, 0, 0, 0, make_code(3, 300, 200, 256, 0)));
    send_item(pack_item(-1, -1, -1, -1, 32'hFFFF_FFFF));
    send_item(pack_item(-1, -1, -1, -1, 32'h0000_0000));
  endtask

  task automatic test_encode_random(input int count);
    set_direction(DIR_ENCODE);
    repeat (count) send_item(random_quaternion_item());
  endtask

  task automatic test_decode_random(input int count);
    set_direction(DIR_DECODE);
    repeat (count) send_item(random_code_item());
  endtask

  // Short phases with the direction flipped, and twice rewritten unchanged.
  task automatic test_direction_switching();
    logic dir;
    for (int phase = 0; phase < 8; phase++) begin
      dir = (phase == 3) ? DIR_ENCODE : ((phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
      set_direction(dir);
      repeat (12) begin
        if (dir == DIR_ENCODE) begin
          send_item(random_quaternion_item());
        end else begin
          send_item(random_code_item());
        end
      end
    end
  endtask

  // The receiver holds off while the sender streams without gaps, so the
  // pipeline fills up and the input side has to stall.
  task automatic test_output_backpressure();
    set_direction(DIR_DECODE);
    gaps_enabled = 1'b0;
    hold_request = 300;
    repeat (60) send_item(random_code_item());
    gaps_enabled = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_directed();
    test_decode_directed();
    test_encode_random(300);
    test_decode_random(300);
    test_direction_switching();
    test_output_backpressure();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // The ready pattern switches to a random mode after each random-length run;
  // a requested hold-off takes priority and is counted out here.
  initial begin : sink_ready
    ready_mode_t mode;
    int mode_left;
    int phase;
    mode = READY_FREE;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 120);
      end
      mode_left--;
      phase++;
      case (mode)
        READY_FREE:     m_tready <= 1'b1;
        READY_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
        READY_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
        READY_PERIODIC: m_tready <= ((phase % 8) >= 3);
        default:        m_tready <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic compare_field(input string field, input logic [CODE_W-1:0] expected_val,
                               input logic [CODE_W-1:0] actual_val);
    if (expected_val !== actual_val) begin
      if (error_count < MAX_REPORTS) begin
        $display("result %0d: %s expected %h, got %h", result_count, field,
                 expected_val, actual_val);
      end
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    codec_result_t expected_res;
    codec_result_t actual_res;
    if (!rst && m_tvalid && m_tready) begin
      actual_res = m_tdata;
      actual_res.code_word = m_tdata[CODE_W-1:0];
      actual_res.out_x = m_tdata[CODE_W +: COMP_W];
      actual_res.out_y = m_tdata[CODE_W + COMP_W +: COMP_W];
      actual_res.out_z = m_tdata[CODE_W + 2*COMP_W +: COMP_W];
      actual_res.out_w = m_tdata[CODE_W + 3*COMP_W +: COMP_W];
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("result %0d: transfer with nothing pending, data %h", result_count, m_tdata);
        end
        error_count++;
      end else begin
        expected_res = pending_results.pop_front();
        compare_field("code_word", expected_res.code_word, actual_res.code_word);
        compare_field("out_x", CODE_W'(expected_res.out_x), CODE_W'(actual_res.out_x));
        compare_field("out_y", CODE_W'(expected_res.out_y), CODE_W'(actual_res.out_y));
        compare_field("out_z", CODE_W'(expected_res.out_z), CODE_W'(actual_res.out_z));
        compare_field("out_w", CODE_W'(expected_res.out_w), CODE_W'(actual_res.out_w));
      end
      result_count++;
    end
  end

endmodule
